[hw/rtl/bba_pkg.sv]
`default_nettype none

package bba_pkg;

  // Pool capacity and derived widths
  localparam int MAX_BLOCKS = 64;
  localparam int IDX_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int BIT_W      = 3;
  localparam int MAP_W      = 1 << BIT_W;
  localparam int MAP_DEPTH  = (MAX_BLOCKS + MAP_W - 1) / MAP_W;
  localparam int ROW_W      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  // Fixed field widths
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 16;
  localparam int COUNT_W    = 7;
  localparam int OUT_IDX_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Offset of the highest block start from the pool base
  localparam int OFF_W = IDX_W + SIZE_W;
  // Width for block index / count compares
  localparam int CMP_W = (IDX_W + 2 > COUNT_W + 1) ? IDX_W + 2 : COUNT_W + 1;
  // Divider step counter
  localparam int KW    = (IDX_W > 1) ? $clog2(IDX_W) : 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd2;

  // Reset values
  localparam logic [ADDR_W-1:0]  POOL_BASE_RST   = 32'd0;
  localparam logic [SIZE_W-1:0]  BLOCK_SIZE_RST  = 16'd16;
  localparam logic [COUNT_W-1:0] BLOCK_COUNT_RST = 7'd64;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_SIZE = 2'd2,
    ST_ADDR = 2'd3
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [SIZE_W-1:0]   request_size;
    logic [ADDR_W-1:0]   block_address;
  } req_word_t;

  typedef struct packed {
    status_t              status;
    logic [ADDR_W-1:0]    address;
    logic [OUT_IDX_W-1:0] block_index;
  } rsp_word_t;

  // Live configuration, count already saturated to capacity
  typedef struct packed {
    logic [ADDR_W-1:0] pool_base;
    logic [SIZE_W-1:0] block_size;
    logic [CMP_W-1:0]  active_count;
  } cfg_t;

  // Used-map RAM access
  typedef struct packed {
    logic             re;
    logic [ROW_W-1:0] raddr;
    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [MAP_W-1:0] wdata;
  } ram_req_t;

endpackage

`default_nettype wire

[hw/rtl/bba_ram.sv]
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bba_cfg.sv]
`default_nettype none

module bba_cfg
  import bba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [ADDR_W-1:0]  pool_base;
  logic [SIZE_W-1:0]  block_size;
  logic [COUNT_W-1:0] block_count;

  // Register file, upper data bits dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base   <= POOL_BASE_RST;
      block_size  <= BLOCK_SIZE_RST;
      block_count <= BLOCK_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POOL_BASE:   pool_base   <= cfg_data[ADDR_W-1:0];
        CFG_BLOCK_SIZE:  block_size  <= cfg_data[SIZE_W-1:0];
        CFG_BLOCK_COUNT: block_count <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Count is clamped to the built capacity
  always_comb begin
    cfg.pool_base  = pool_base;
    cfg.block_size = block_size;
    if (CMP_W'(block_count) > CMP_W'(MAX_BLOCKS)) begin
      cfg.active_count = CMP_W'(MAX_BLOCKS);
    end else begin
      cfg.active_count = CMP_W'(block_count);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bba_ctrl.sv]
`default_nettype none

module bba_ctrl
  import bba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             req_valid,
  output logic             req_ready,
  input  req_word_t        req_word,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output rsp_word_t        rsp_word,
  output ram_req_t         ram,
  input  logic [MAP_W-1:0] ram_rdata
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_RD,
    S_A_CHK,
    S_A_MUL,
    S_A_ADD,
    S_F_RANGE,
    S_F_DIV,
    S_F_CHK,
    S_F_WR,
    S_DONE
  } state_t;

  state_t           state;
  logic [ROW_W-1:0] word;
  logic [ADDR_W-1:0] blk_addr;
  logic [OFF_W-1:0] prod;
  logic [OFF_W-1:0] rem;
  logic             hi_bad;
  logic [IDX_W-1:0] q;
  logic [KW-1:0]    k;
  status_t          res_status;
  logic [ADDR_W-1:0] res_addr;
  logic [IDX_W-1:0] res_idx;
  logic [MAP_DEPTH-1:0] row_valid;
  logic             rd_valid;

  logic [MAP_W-1:0] data_eff;
  logic [CMP_W-1:0] base_i;
  logic [MAP_W-1:0] in_rng;
  logic [MAP_W-1:0] free_bits;
  logic             hit;
  logic [BIT_W-1:0] hit_bit;
  logic             last_row;
  logic [ADDR_W-1:0] diff;
  logic [OFF_W-1:0] trial;
  logic [OFF_W-1:0] limit;
  logic [ROW_W-1:0] q_row;

  assign req_ready = (state == S_IDLE);

  // Scan of one map row: lowest free block below the active count
  always_comb begin
    data_eff  = rd_valid ? ram_rdata : '0;
    base_i    = CMP_W'(word) << BIT_W;
    for (int b = 0; b < MAP_W; b++) begin
      in_rng[b] = (base_i + CMP_W'(b)) < cfg.active_count;
    end
    free_bits = ~data_eff & in_rng;
    hit       = |free_bits;
    hit_bit   = '0;
    for (int b = MAP_W - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        hit_bit = BIT_W'(b);
      end
    end
    last_row  = (base_i + CMP_W'(MAP_W)) >= cfg.active_count;
  end

  // Free path arithmetic
  assign diff  = req_word.block_address - cfg.pool_base;
  assign trial = OFF_W'(cfg.block_size) << k;
  assign limit = OFF_W'(cfg.block_size) << IDX_W;
  assign q_row = ROW_W'(q >> BIT_W);

  // Map RAM port control
  always_comb begin
    ram.re    = 1'b0;
    ram.raddr = word;
    ram.we    = 1'b0;
    ram.waddr = word;
    ram.wdata = data_eff | (MAP_W'(1) << hit_bit);
    case (state)
      S_A_RD:  ram.re = 1'b1;
      S_A_CHK: ram.we = hit;
      S_F_CHK: begin
        ram.re    = 1'b1;
        ram.raddr = q_row;
      end
      S_F_WR: begin
        ram.we    = 1'b1;
        ram.waddr = q_row;
        ram.wdata = data_eff & ~(MAP_W'(1) << BIT_W'(q));
      end
      default: ;
    endcase
  end

  // Row valid bits: a row never written reads as all free
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (ram.we) begin
        row_valid[ram.waddr] <= 1'b1;
      end
      if (ram.re) begin
        rd_valid <= row_valid[ram.raddr];
      end
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // word taken and no new one loaded this cycle
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            blk_addr   <= req_word.block_address;
            res_addr   <= '0;
            res_idx    <= '0;
            word       <= '0;
            rem        <= diff[OFF_W-1:0];
            hi_bad     <= |diff[ADDR_W-1:OFF_W];
            q          <= '0;
            k          <= KW'(IDX_W - 1);
            if (req_word.action == ACT_FREE) begin
              res_status <= ST_OK;
              state      <= S_F_RANGE;
            end else if (req_word.request_size != cfg.block_size) begin
              res_status <= ST_SIZE;
              state      <= S_DONE;
            end else begin
              res_status <= ST_OK;
              state      <= S_A_RD;
            end
          end
        end
        S_A_RD: state <= S_A_CHK;
        S_A_CHK: begin
          if (hit) begin
            res_idx <= IDX_W'(base_i | CMP_W'(hit_bit));
            state   <= S_A_MUL;
          end else if (last_row) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            word  <= word + 1'b1;
            state <= S_A_RD;
          end
        end
        S_A_MUL: begin
          prod  <= OFF_W'(res_idx) * OFF_W'(cfg.block_size);
          state <= S_A_ADD;
        end
        S_A_ADD: begin
          res_addr <= cfg.pool_base + ADDR_W'(prod);
          state    <= S_DONE;
        end
        S_F_RANGE: begin
          if (cfg.block_size == '0) begin
            state <= S_F_CHK;
          end else if (hi_bad || (rem >= limit)) begin
            res_status <= ST_ADDR;
            state      <= S_DONE;
          end else begin
            state <= S_F_DIV;
          end
        end
        // Restoring division, one quotient bit per cycle
        S_F_DIV: begin
          if (rem >= trial) begin
            rem  <= rem - trial;
            q[k] <= 1'b1;
          end
          if (k == '0) begin
            state <= S_F_CHK;
          end else begin
            k <= k - 1'b1;
          end
        end
        S_F_CHK: begin
          if (!hi_bad && (rem == '0) && (CMP_W'(q) < cfg.active_count)) begin
            state <= S_F_WR;
          end else begin
            res_status <= ST_ADDR;
            state      <= S_DONE;
          end
        end
        S_F_WR: begin
          res_addr <= blk_addr;
          res_idx  <= q;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid            <= 1'b1;
            rsp_word.status      <= res_status;
            rsp_word.address     <= res_addr;
            rsp_word.block_index <= OUT_IDX_W'(res_idx);
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/bitmap_block_allocator.sv]
`default_nettype none

// Fixed-size block allocator over a used-bit map.
// Request channel (req_valid/req_ready/req_word): one word per request,
// either an allocate (request_size must equal block_size) or a free
// (block_address names a block start). Every request returns exactly one
// word on the response channel (rsp_valid/rsp_ready/rsp_word) with status,
// address and block_index. Requests are handled one at a time.
// Path from accept to rsp_valid (size mismatch: straight to the response):
//   allocate        one RAM read and a check per map row (8 blocks per row, up
//                   to 8 rows), then multiply and add; full after the last row
//   free            range check, 6-step divide for the index, then
//                   read-modify-write of one map row; ends at the range check
//                   when out of range, at the index check when not a block
//                   start; block size zero skips the range check and divide
// req_ready returns together with rsp_valid, when the response is loaded.
// Configuration (cfg_we/cfg_index/cfg_data) is for the user to write while
// idle; the block itself does not enforce it.
// Reset: base 0, size 16, count 64, every block free at once (per-row
// valid bits, no clearing pass).
// A stalled receiver holds the response in the output register; the next
// request is accepted meanwhile and its result waits until that word leaves.
module bitmap_block_allocator
  import bba_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  req_word_t             req_word,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output rsp_word_t             rsp_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t             cfg;
  ram_req_t         ram;
  logic [MAP_W-1:0] ram_rdata;

  bba_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word),
    .ram       (ram),
    .ram_rdata (ram_rdata)
  );

  // Used map, MAP_W blocks per row
  bba_ram #(
    .WIDTH (MAP_W),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

[hw/rtl/bba_checker.sv]
`default_nettype none

module bba_checker
  import bba_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      req_valid,
  input logic      req_ready,
  input req_word_t req_word,
  input logic      rsp_valid,
  input logic      rsp_ready,
  input rsp_word_t rsp_word
);

  // Reset leaves the block idle with no response pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (req_ready && !rsp_valid))
    else $error("not idle after reset");

  // One request at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while busy");

  // Failed requests carry zero address and index
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_word.status != ST_OK)) |->
      ((rsp_word.address == '0) && (rsp_word.block_index == '0)))
    else $error("failed response with nonzero payload");

  // A stalled response word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word)))
    else $error("response word dropped or changed while stalled");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req_word  (req_word),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_word  (rsp_word)
);

`default_nettype wire

[dv/testbench.sv]
module testbench;
  import bba_pkg::*;

  // Index 3 decodes to no register; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 120;
  localparam int HOLD_AT     = 600;  // response count that triggers the long hold
  localparam int LONG_HOLD   = 400;  // cycles the response side holds off then
  localparam int TAIL_CYCLES = 40;

  typedef enum logic [1:0] {
    ROW_REQ,  // request, outcome from the pool predictor
    ROW_CHK,  // request, outcome typed into the table
    ROW_CFG   // register write once the pool is idle
  } row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_data;
    req_word_t             word;
    rsp_word_t             want;
  } plan_row_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_ready;
  req_word_t             req_word  = '0;
  logic                  rsp_valid;
  logic                  rsp_ready = 1'b0;
  rsp_word_t             rsp_word;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Shadow of the pool: registers and used map
  logic [ADDR_W-1:0]     cur_base  = POOL_BASE_RST;
  logic [SIZE_W-1:0]     cur_size  = BLOCK_SIZE_RST;
  logic [COUNT_W-1:0]    cur_count = BLOCK_COUNT_RST;
  logic [MAX_BLOCKS-1:0] used_bits = '0;

  rsp_word_t pending_outcomes [$];
  int        mismatches    = 0;
  int        words_sent    = 0;
  int        reg_writes    = 0;
  int        outcome_mix [4] = '{default: 0};
  bit        sender_steady = 1'b0;
  bit        long_hold_hit = 1'b0;

  // Opening sequence: reset settings, wrap-around, saturated count, zero size,
  // zero count, count shrunk below blocks in use
  plan_row_t plan [31] = '{
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_ALLOC, 16'd16, 32'h0}, '{ST_OK, 32'h0, 6'd0}},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_ALLOC, 16'd15, 32'hFFFF_FFFF},
      '{ST_SIZE, 32'h0, 6'd0}},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_ALLOC, 16'hFFFF, 32'h0}, '{ST_SIZE, 32'h0, 6'd0}},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_FREE, 16'hFFFF, 32'h0}, '{ST_OK, 32'h0, 6'd0}},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_FREE, 16'h0, 32'h0}, '{ST_OK, 32'h0, 6'd0}},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_FREE, 16'h0, 32'h8}, '{ST_ADDR, 32'h0, 6'd0}},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_FREE, 16'h0, 32'hFFFF_FFFF},
      '{ST_ADDR, 32'h0, 6'd0}},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_FREE, 16'h0, 32'h3F0}, '{ST_OK, 32'h3F0, 6'd63}},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_FREE, 16'h0, 32'h400}, '{ST_ADDR, 32'h0, 6'd0}},
    '{ROW_CFG, CFG_UNUSED, 32'hFFFF_FFFF, '0, '0},
    '{ROW_CFG, CFG_POOL_BASE, 32'hFFFF_FFF0, '0, '0},
    '{ROW_CFG, CFG_BLOCK_SIZE, 32'h0000_FFFF, '0, '0},
    '{ROW_CFG, CFG_BLOCK_COUNT, 32'd2, '0, '0},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_ALLOC, 16'hFFFF, 32'h0},
      '{ST_OK, 32'hFFFF_FFF0, 6'd0}},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_ALLOC, 16'hFFFF, 32'h0},
      '{ST_OK, 32'h0000_FFEF, 6'd1}},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_ALLOC, 16'hFFFF, 32'h0}, '{ST_FULL, 32'h0, 6'd0}},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_ALLOC, 16'h0, 32'h0}, '{ST_SIZE, 32'h0, 6'd0}},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_FREE, 16'h0, 32'h0000_FFEF},
      '{ST_OK, 32'h0000_FFEF, 6'd1}},
    '{ROW_CFG, CFG_BLOCK_COUNT, 32'hFFFF_FFFF, '0, '0},
    '{ROW_CFG, CFG_BLOCK_SIZE, 32'hABCD_0000, '0, '0},
    '{ROW_REQ, CFG_POOL_BASE, 32'h0, '{ACT_ALLOC, 16'h0, 32'h0}, '0},
    '{ROW_REQ, CFG_POOL_BASE, 32'h0, '{ACT_FREE, 16'h0, 32'hFFFF_FFF0}, '0},
    '{ROW_CFG, CFG_BLOCK_COUNT, 32'd0, '0, '0},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_ALLOC, 16'h0, 32'h0}, '{ST_FULL, 32'h0, 6'd0}},
    '{ROW_CHK, CFG_POOL_BASE, 32'h0, '{ACT_FREE, 16'h0, 32'hFFFF_FFF0},
      '{ST_ADDR, 32'h0, 6'd0}},
    '{ROW_CFG, CFG_POOL_BASE, 32'h0, '0, '0},
    '{ROW_CFG, CFG_BLOCK_SIZE, 32'd1, '0, '0},
    '{ROW_CFG, CFG_BLOCK_COUNT, 32'd1, '0, '0},
    '{ROW_REQ, CFG_POOL_BASE, 32'h0, '{ACT_ALLOC, 16'd1, 32'h0}, '0},
    '{ROW_REQ, CFG_POOL_BASE, 32'h0, '{ACT_FREE, 16'h0, 32'h1}, '0},
    '{ROW_REQ, CFG_POOL_BASE, 32'h0, '{ACT_ALLOC, 16'd1, 32'h0}, '0}
  };

  bitmap_block_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_word  (rsp_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Blocks actually scanned: count saturates at capacity
  function automatic int active_blocks();
    return (int'(cur_count) > MAX_BLOCKS) ? MAX_BLOCKS : int'(cur_count);
  endfunction

  function automatic logic [ADDR_W-1:0] block_start(input int idx);
    return cur_base + ADDR_W'(idx) * ADDR_W'(cur_size);
  endfunction

  // Outcome of one request; updates the shadow used map
  function automatic rsp_word_t pool_outcome(input req_word_t w);
    rsp_word_t r;
    int n;
    bit hit;
    r = '0;
    n = active_blocks();
    hit = 1'b0;
    if (w.action == ACT_ALLOC) begin
      // size check wins over a full pool
      if (w.request_size != cur_size) begin
        r.status = ST_SIZE;
      end else begin
        for (int i = 0; i < n && !hit; i++) begin
          if (!used_bits[i]) begin
            used_bits[i] = 1'b1;
            r.address = block_start(i);
            r.block_index = OUT_IDX_W'(i);
            hit = 1'b1;
          end
        end
        if (!hit) r.status = ST_FULL;
      end
    end else begin
      // first matching start wins; freeing a free block is still ok
      for (int i = 0; i < n && !hit; i++) begin
        if (block_start(i) == w.block_address) begin
          used_bits[i] = 1'b0;
          r.address = w.block_address;
          r.block_index = OUT_IDX_W'(i);
          hit = 1'b1;
        end
      end
      if (!hit) r.status = ST_ADDR;
    end
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_POOL_BASE:   cur_base = data[ADDR_W-1:0];
      CFG_BLOCK_SIZE:  cur_size = data[SIZE_W-1:0];
      CFG_BLOCK_COUNT: cur_count = data[COUNT_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // Offer one request word, log its outcome on accept, then maybe idle
  task automatic send_word(input req_word_t w, input bit from_table,
                           input rsp_word_t table_rsp);
    rsp_word_t pred;
    int gap;
    int r;
    req_valid <= 1'b1;
    req_word <= w;
    do @(posedge clk); while (!req_ready);
    pred = pool_outcome(w);
    pending_outcomes.push_back(from_table ? table_rsp : pred);
    outcome_mix[int'(pred.status)]++;
    words_sent++;
    r = $urandom_range(99);
    if (sender_steady || r < 70) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else if (r < 98) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 60);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every outcome has come back; with nothing
  // pending the request line is already low
  task automatic settle();
    if (pending_outcomes.size() != 0) begin
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clk);
    end
  endtask

  // Request side: reset, directed table, then randomized pool phases
  initial begin : request_side
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] bsize;
    logic [COUNT_W-1:0] count;
    req_word_t w;
    int alloc_pct;
    int n;
    int idx;
    int r;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      case (plan[k].kind)
        ROW_CFG: begin
          settle();
          write_reg(plan[k].reg_idx, plan[k].reg_data);
        end
        ROW_CHK: send_word(plan[k].word, 1'b1, plan[k].want);
        default: send_word(plan[k].word, 1'b0, '0);
      endcase
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      // first phases pin the register extremes
      case (ph)
        0: begin base = '0; bsize = 16'd1; count = 7'd64; end
        1: begin base = '1; bsize = 16'hFFFF; count = 7'd1; end
        2: begin base = $urandom(); bsize = 16'hFFFF; count = 7'd64; end
        3: begin base = '1; bsize = 16'd1; count = 7'h7F; end
        default: begin
          base = $urandom();
          r = $urandom_range(99);
          if (r < 4) bsize = 16'd0;
          else if (r < 14) bsize = 16'd1;
          else if (r < 24) bsize = 16'hFFFF;
          else bsize = 16'($urandom_range(1, 65535));
          r = $urandom_range(99);
          if (r < 4) count = 7'd0;
          else if (r < 10) count = 7'($urandom_range(65, 127));
          else if (r < 30) count = 7'd64;
          else count = 7'($urandom_range(1, 16));
        end
      endcase
      settle();
      write_reg(CFG_POOL_BASE, base);
      write_reg(CFG_BLOCK_SIZE, {16'($urandom()), bsize});
      write_reg(CFG_BLOCK_COUNT, {25'($urandom()), count});
      alloc_pct = 35 + 20 * $urandom_range(3);
      sender_steady = ($urandom_range(3) == 0);

      for (int i = 0; i < PHASE_WORDS; i++) begin
        // one drain in mid-phase with blocks still held
        if (ph == PHASES / 2 && i == PHASE_WORDS / 2) settle();
        n = active_blocks();
        w.request_size = 16'($urandom());
        w.block_address = $urandom();
        if ($urandom_range(99) < alloc_pct) begin
          w.action = ACT_ALLOC;
          if ($urandom_range(99) < 88) w.request_size = cur_size;
        end else begin
          w.action = ACT_FREE;
          r = $urandom_range(99);
          if (n > 0 && r < 50) begin
            // aim at a block in use when one exists
            idx = $urandom_range(n - 1);
            for (int k = 0; k < n && !used_bits[idx]; k++) idx = (idx + 1) % n;
            w.block_address = block_start(idx);
          end else if (n > 0 && r < 80) begin
            w.block_address = block_start($urandom_range(n - 1));
          end else if (r < 90) begin
            // any start, possibly past the count, or one byte off it
            idx = $urandom_range(MAX_BLOCKS - 1);
            w.block_address = block_start(idx) + ADDR_W'($urandom_range(2)) - 1;
          end
        end
        send_word(w, 1'b0, '0);
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d request words (%0d from the table) over %0d register writes;",
             words_sent, 21, reg_writes);
    $display("outcomes ok %0d, full %0d, size mismatch %0d, bad address %0d, long hold %0s",
             outcome_mix[0], outcome_mix[1], outcome_mix[2], outcome_mix[3],
             long_hold_hit ? "seen" : "missed");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Response side: compare each word, drive ready with random holds
  initial begin : response_side
    rsp_word_t want;
    int stall_left;
    int words_seen;
    bit ready_steady;
    int r;
    stall_left = 0;
    words_seen = 0;
    ready_steady = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_valid && rsp_ready) begin
        words_seen++;
        if (pending_outcomes.size() == 0) begin
          $error("response word with nothing pending: status %0d address %h index %0d",
                 rsp_word.status, rsp_word.address, rsp_word.block_index);
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          if (rsp_word.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_word.status);
            mismatches++;
          end
          if (rsp_word.address !== want.address) begin
            $error("address: expected %h, got %h", want.address, rsp_word.address);
            mismatches++;
          end
          if (rsp_word.block_index !== want.block_index) begin
            $error("block_index: expected %0d, got %0d", want.block_index,
                   rsp_word.block_index);
            mismatches++;
          end
        end
      end
      // one long hold so the allocator backs up into its request port
      if (!long_hold_hit && words_seen >= HOLD_AT) begin
        long_hold_hit = 1'b1;
        stall_left = LONG_HOLD;
      end
      if ($urandom_range(149) == 0) ready_steady = !ready_steady;
      if (stall_left == 0 && !ready_steady) begin
        r = $urandom_range(99);
        if (r < 14) stall_left = $urandom_range(1, 3);
        else if (r < 16) stall_left = $urandom_range(20, 60);
      end
      if (stall_left > 0) begin
        rsp_ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #10_000_000;
    $error("run timed out with %0d words pending", pending_outcomes.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
